/* hdl/npcs_pkg.sv */
// Shared types and constants for the nearest palette colour search block.
// No dependencies; used by every module in hdl/ except npcs_ram.
package npcs_pkg;

   // tuser coding of a request transaction
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Register indexes of the configuration port
   localparam logic CSR_PALETTE_IS_RGB565 = 1'b0;
   localparam logic CSR_PIXEL_HAS_ALPHA   = 1'b1;

   // Request tdata layout, lowest bit first
   localparam int REQ_TDATA_W   = 64;
   localparam int ENTRY_IDX_LSB = 0;
   localparam int ENTRY_VAL_LSB = 8;
   localparam int RED_LSB       = 32;
   localparam int GREEN_LSB     = 40;
   localparam int BLUE_LSB      = 48;
   localparam int ALPHA_LSB     = 56;

   localparam int ENTRY_W = 24;
   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int ERR_W   = SQ_W + 2;     // 3 * 255^2 = 195075 < 2^18
   localparam int RSP_W   = 8;

   // Alpha below this makes a pixel transparent
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE_MIN = 8'h80;
   // Larger than any real error, so the first entry always wins
   localparam logic [ERR_W-1:0]  ERR_INIT = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic write_entry;   // store req entry into the palette
      logic load_pixel;    // latch pixel channels, reset best match
      logic issue;         // read palette at the search address
      logic load_result;   // load the response register
      logic result_zero;   // response is index 0 (transparent pixel)
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy;          // compare pipeline still holds entries
      logic transparent;   // request pixel is transparent
   } status_type;

endpackage

/* hdl/npcs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/npcs_ctrl.sv */
// Controller FSM: request handshake, palette address sweep, response valid.
// Depends on npcs_pkg.
module npcs_ctrl #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  npcs_pkg::status_type            status,
   output npcs_pkg::cmd_type               cmd,
   output logic [$clog2(PALETTE_SIZE)-1:0] search_addr
);

   localparam int IW = $clog2(PALETTE_SIZE);
   localparam logic [IW-1:0] LAST_ADDR = IW'(PALETTE_SIZE - 1);
   localparam logic [IW-1:0] FIRST_ADDR = IW'(1);

   npcs_pkg::state_type state_ff, state_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic          zero_ff, zero_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npcs_pkg::ST_IDLE;
         addr_ff      <= FIRST_ADDR;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      zero_in    = zero_ff;
      cmd        = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         npcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == npcs_pkg::KIND_WRITE) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.load_pixel = 1'b1;
                  addr_in        = FIRST_ADDR;
                  zero_in        = status.transparent;
                  state_in       = status.transparent ? npcs_pkg::ST_DONE
                                                      : npcs_pkg::ST_SEARCH;
               end
            end
         end
         npcs_pkg::ST_SEARCH: begin
            cmd.issue = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = npcs_pkg::ST_DRAIN;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (!status.busy) begin
               state_in = npcs_pkg::ST_DONE;
            end
         end
         npcs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_result = 1'b1;
               cmd.result_zero = zero_ff;
               state_in        = npcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase

      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign search_addr = addr_ff;

endmodule

/* hdl/npcs_datapath.sv */
// Datapath: config registers, palette RAM, squared-error pipeline, best match,
// response data register. Depends on npcs_pkg and npcs_ram.
module npcs_datapath #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic                                 csr_wdata,
   input  logic [npcs_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  npcs_pkg::cmd_type                    cmd,
   input  logic [$clog2(PALETTE_SIZE)-1:0]      search_addr,
   output npcs_pkg::status_type                 status,
   output logic [npcs_pkg::RSP_W-1:0]           rsp_tdata
);

   localparam int IW = $clog2(PALETTE_SIZE);
   localparam int CW = npcs_pkg::CHAN_W;

   // ---------------- configuration ----------------
   logic rgb565_ff, has_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb565_ff    <= 1'b0;
         has_alpha_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            npcs_pkg::CSR_PALETTE_IS_RGB565: rgb565_ff    <= csr_wdata;
            npcs_pkg::CSR_PIXEL_HAS_ALPHA:   has_alpha_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- request fields ----------------
   logic [7:0]                  entry_index;
   logic [npcs_pkg::ENTRY_W-1:0] entry_value;
   logic [CW-1:0]               req_red, req_green, req_blue, req_alpha;

   assign entry_index = req_tdata[npcs_pkg::ENTRY_IDX_LSB +: 8];
   assign entry_value = req_tdata[npcs_pkg::ENTRY_VAL_LSB +: npcs_pkg::ENTRY_W];
   assign req_red     = req_tdata[npcs_pkg::RED_LSB   +: CW];
   assign req_green   = req_tdata[npcs_pkg::GREEN_LSB +: CW];
   assign req_blue    = req_tdata[npcs_pkg::BLUE_LSB  +: CW];
   assign req_alpha   = req_tdata[npcs_pkg::ALPHA_LSB +: CW];

   assign status.transparent = has_alpha_ff && (req_alpha < npcs_pkg::ALPHA_OPAQUE_MIN);

   // slots at or beyond the palette size are dropped
   logic slot_ok;
   assign slot_ok = {1'b0, entry_index} < 9'(PALETTE_SIZE);

   // ---------------- palette RAM ----------------
   logic [npcs_pkg::ENTRY_W-1:0] rd_entry;

   npcs_ram #(
      .WIDTH (npcs_pkg::ENTRY_W),
      .DEPTH (PALETTE_SIZE)
   ) u_palette (
      .clock   (clock),
      .wr_en   (cmd.write_entry && slot_ok),
      .wr_addr (entry_index[IW-1:0]),
      .wr_data (entry_value),
      .rd_en   (cmd.issue),
      .rd_addr (search_addr),
      .rd_data (rd_entry)
   );

   // ---------------- pixel latch ----------------
   logic [CW-1:0] pix_r_ff, pix_g_ff, pix_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
      end
   end

   // ---------------- stage 1: RAM read data ----------------
   logic          s1_valid_ff;
   logic [IW-1:0] s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
      s1_idx_ff <= search_addr;
   end

   // ---------------- stage 2: expand, diff, square ----------------
   logic [CW-1:0] ent_r, ent_g, ent_b;
   logic [CW-1:0] dr, dg, db;

   always_comb begin
      if (rgb565_ff) begin
         ent_r = {rd_entry[15:11], 3'b000};
         ent_g = {rd_entry[10:5],  2'b00};
         ent_b = {rd_entry[4:0],   3'b000};
      end else begin
         ent_r = rd_entry[23:16];
         ent_g = rd_entry[15:8];
         ent_b = rd_entry[7:0];
      end
      dr = (pix_r_ff > ent_r) ? pix_r_ff - ent_r : ent_r - pix_r_ff;
      dg = (pix_g_ff > ent_g) ? pix_g_ff - ent_g : ent_g - pix_g_ff;
      db = (pix_b_ff > ent_b) ? pix_b_ff - ent_b : ent_b - pix_b_ff;
   end

   logic                      s2_valid_ff;
   logic [IW-1:0]             s2_idx_ff;
   logic [npcs_pkg::SQ_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= npcs_pkg::SQ_W'(dr) * npcs_pkg::SQ_W'(dr);
      sq_g_ff   <= npcs_pkg::SQ_W'(dg) * npcs_pkg::SQ_W'(dg);
      sq_b_ff   <= npcs_pkg::SQ_W'(db) * npcs_pkg::SQ_W'(db);
   end

   // ---------------- stage 3: sum and keep best ----------------
   logic [npcs_pkg::ERR_W-1:0] err_sum;
   logic [npcs_pkg::ERR_W-1:0] best_err_ff, best_err_in;
   logic [IW-1:0]              best_idx_ff, best_idx_in;

   assign err_sum = npcs_pkg::ERR_W'(sq_r_ff) + npcs_pkg::ERR_W'(sq_g_ff)
                  + npcs_pkg::ERR_W'(sq_b_ff);

   always_comb begin
      best_err_in = best_err_ff;
      best_idx_in = best_idx_ff;
      priority if (cmd.load_pixel) begin
         best_err_in = npcs_pkg::ERR_INIT;
         best_idx_in = IW'(1);
      end else if (s2_valid_ff && (err_sum < best_err_ff)) begin
         // strict compare keeps the lowest index on a tie
         best_err_in = err_sum;
         best_idx_in = s2_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_err_ff <= best_err_in;
      best_idx_ff <= best_idx_in;
   end

   assign status.busy = s1_valid_ff || s2_valid_ff;

   // ---------------- response data ----------------
   logic [npcs_pkg::RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_data_ff <= cmd.result_zero ? '0 : npcs_pkg::RSP_W'(best_idx_ff);
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

/* hdl/nearest_palette_colour_search.sv */
// Top level of the nearest palette colour search block.
// Depends on npcs_pkg, npcs_ctrl, npcs_datapath (which holds npcs_ram).
//
// Usage:
//   req channel: one transaction is either a palette write (tuser = 0) or a
//   pixel (tuser = 1). A write stores entry_value at entry_index and gives no
//   response; slots at or above PALETTE_SIZE are dropped.
//   A pixel gives one rsp transaction carrying the palette index whose colour
//   has the smallest summed squared RGB error (entries 1..PALETTE_SIZE-1,
//   lowest index on a tie). With alpha mode on, alpha below 0x80 answers 0.
//   Sequence: a searched pixel reads the palette RAM, one entry per cycle
//   over PALETTE_SIZE-1 entries, then drains the compare pipeline, then
//   loads the response register; a transparent pixel skips straight to the
//   response load. No new request is taken until that load; writes go one
//   per cycle while the controller is idle. req_tready is high only while
//   the controller is idle.
//   Stall: the response sits in an output register, so the next transaction
//   is taken while rsp waits; a finished search holds until rsp drains.
//   Reset: synchronous, clears control state and both config registers. The
//   palette is not cleared: every searched entry must be written before use.
//   csr: write-only, csr_index 0 = palette_is_rgb565, 1 = pixel_has_alpha.
module nearest_palette_colour_search #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: entry_index[7:0], entry_value[31:8], red[39:32], green[47:40],
   //        blue[55:48], alpha[63:56]
   input  logic [63:0] req_tdata,
   // tuser: kind[0]
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: palette_index[7:0]
   output logic [7:0]  rsp_tdata
);

   localparam int IW = $clog2(PALETTE_SIZE);

   npcs_pkg::cmd_type    cmd;
   npcs_pkg::status_type status;
   logic [IW-1:0]        search_addr;

   // sequencer: handshake, address sweep, response valid
   npcs_ctrl #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd),
      .search_addr (search_addr)
   );

   // palette store, error pipeline and best-match tracking
   npcs_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .search_addr (search_addr),
      .status      (status),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* hdl/npcs_checker.sv */
// Port-level checker for nearest_palette_colour_search, bound to the top level.
// Depends on npcs_pkg.
module npcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped or changed under stall");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // a palette write never produces a response
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == npcs_pkg::KIND_WRITE) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("response after palette write");

   // a pixel transaction blocks the request side while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == npcs_pkg::KIND_PIXEL) |=> !req_tready)
      else $error("request taken during pixel search");

endmodule

bind nearest_palette_colour_search npcs_checker u_npcs_checker (.*);

/* dv/nearest_palette_colour_search_tb.sv */
// Self-checking testbench for nearest_palette_colour_search: palette writes and
// pixel lookups driven on the req stream, responses checked against a local predictor.
// Depends on npcs_pkg and the RTL under hdl/.
module nearest_palette_colour_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PALETTE_SIZE = 256;
   // generous ceiling for the whole run
   localparam longint TIMEOUT_NS = 20_000_000;
   // long receiver hold-off used to back the block up
   localparam int LONG_HOLD_CYCLES = 1500;

   // one queued request transaction: tuser plus packed tdata
   typedef struct packed {
      logic        kind;
      logic [63:0] data;
   } req_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   // stimulus side
   req_beat_type pending_req_q[$];
   logic [23:0] palette_plan[PALETTE_SIZE];   // palette as the stimulus will leave it
   int          req_gap_left = 0;
   int          rsp_gap_left = 0;
   int          rsp_hold_left = 0;
   bit          quiet_tail = 1'b0;      // no idling on either side
   bit          pressure_on = 1'b0;
   bit          pressure_started = 1'b0;
   bit          req_taken = 1'b0;       // req transaction accepted at last rising edge

   // predictor state: palette and register copies
   logic [23:0] palette_model[PALETTE_SIZE];
   logic        rgb565_mode = 1'b0;
   logic        alpha_mode = 1'b0;
   logic [7:0]  expected_index_q[$];
   int          mismatch_count = 0;

   nearest_palette_colour_search #(.PALETTE_SIZE(PALETTE_SIZE)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Split a stored entry into 8-bit channels. RGB565 expands by shifting,
   // low bits zero; bits 23..16 are don't-care in that format.
   function automatic void entry_rgb(input logic [23:0] e, input logic is565,
                                     output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
      if (is565) begin
         r = {e[15:11], 3'b000};
         g = {e[10:5], 2'b00};
         b = {e[4:0], 3'b000};
      end else begin
         r = e[23:16];
         g = e[15:8];
         b = e[7:0];
      end
   endfunction

   // Nearest entry over slots 1..N-1 by summed squared error; strict < keeps
   // the lowest index on a tie. Slot 0 only ever comes back for transparency.
   function automatic logic [7:0] predict_palette_index(input logic [7:0] r,
                                                         input logic [7:0] g,
                                                         input logic [7:0] b,
                                                         input logic [7:0] a);
      logic [7:0] er, eg, eb;
      int         err, best_err, dr, dg, db;
      logic [7:0] best;
      if (alpha_mode && a < npcs_pkg::ALPHA_OPAQUE_MIN)
         return 8'd0;
      best = 8'd1;
      best_err = 0;
      for (int i = 1; i < PALETTE_SIZE; i++) begin
         entry_rgb(palette_model[i], rgb565_mode, er, eg, eb);
         dr = int'(r) - int'(er);
         dg = int'(g) - int'(eg);
         db = int'(b) - int'(eb);
         err = dr * dr + dg * dg + db * db;
         if (i == 1 || err < best_err) begin
            best_err = err;
            best = 8'(i);
         end
      end
      return best;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] c);
      int v;
      v = int'(c) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // alpha biased toward the transparency threshold and the extremes
   function automatic logic [7:0] pick_alpha();
      if ($urandom_range(0, 3) != 0)
         return 8'($urandom);
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return npcs_pkg::ALPHA_OPAQUE_MIN - 8'd1;
         2: return npcs_pkg::ALPHA_OPAQUE_MIN;
         default: return 8'hFF;
      endcase
   endfunction

   // Palette write; channel fields carry junk the block must ignore.
   task automatic queue_write(input logic [7:0] slot, input logic [23:0] value);
      req_beat_type beat;
      beat.kind = npcs_pkg::KIND_WRITE;
      beat.data = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), value, slot};
      pending_req_q.push_back(beat);
      palette_plan[slot] = value;
   endtask

   // Pixel lookup; entry fields carry junk.
   task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
      req_beat_type beat;
      beat.kind = npcs_pkg::KIND_PIXEL;
      beat.data = {a, b, g, r, 24'($urandom), 8'($urandom)};
      pending_req_q.push_back(beat);
   endtask

   // Random traffic: ~35% writes (some copying an existing colour to force ties),
   // pixels half the time close to a palette colour so the winner is decided by a few
   // units of error.
   task automatic queue_random_mix(input int count);
      logic [7:0]  r, g, b;
      logic [23:0] v;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 3))
               0, 1: v = 24'($urandom);
               2: v = palette_plan[$urandom_range(1, PALETTE_SIZE - 1)];
               default: v = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            endcase
            queue_write(8'($urandom_range(0, 255)), v);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  entry_rgb(palette_plan[$urandom_range(1, PALETTE_SIZE - 1)],
                            rgb565_mode, r, g, b);
                  r = jitter(r);
                  g = jitter(g);
                  b = jitter(b);
               end
               5, 6, 7: begin
                  r = 8'($urandom);
                  g = 8'($urandom);
                  b = 8'($urandom);
               end
               default: begin
                  r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
            endcase
            queue_pixel(r, g, b, pick_alpha());
         end
      end
   endtask

   // Register write; only called while the block is idle.
   task automatic set_register(input logic idx, input logic value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == npcs_pkg::CSR_PALETTE_IS_RGB565)
         rgb565_mode = value;
      else
         alpha_mode = value;
   endtask

   // Everything sent and answered, then a wait longer than a search so a trailing
   // write is surely retired before the config changes.
   task automatic wait_drained();
      while (pending_req_q.size() != 0 || req_tvalid || expected_index_q.size() != 0)
         @(posedge clock);
      repeat (PALETTE_SIZE + 8) @(posedge clock);
   endtask

   // Request driver: holds a transaction until taken, then optionally idles
   // for a burst before presenting the next.
   always @(negedge clock) begin : drive_requests
      req_beat_type beat;
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // still waiting on tready
         end else if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_req_q.size() != 0) begin
            beat = pending_req_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= beat.kind;
            req_tdata <= beat.data;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
               req_gap_left = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response-side ready: random stall bursts, plus one long hold-off that
   // lets the block finish a search, park it, and back up the req side.
   always @(negedge clock) begin : drive_rsp_ready
      if (pressure_on && !pressure_started) begin
         pressure_started = 1'b1;
         rsp_hold_left = LONG_HOLD_CYCLES;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_tail && $urandom_range(0, 3) == 0)
            rsp_gap_left = $urandom_range(1, 14);
      end
   end

   // Monitor: at each rising edge, apply an accepted request to the predictor
   // and check an accepted response against the oldest expectation.
   always @(posedge clock) begin : observe
      logic [7:0] want;
      logic [7:0] slot;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         if (req_tuser == npcs_pkg::KIND_WRITE) begin
            slot = req_tdata[npcs_pkg::ENTRY_IDX_LSB +: 8];
            if (int'(slot) < PALETTE_SIZE)
               palette_model[slot] = req_tdata[npcs_pkg::ENTRY_VAL_LSB +: npcs_pkg::ENTRY_W];
         end else begin
            expected_index_q.push_back(predict_palette_index(
               req_tdata[npcs_pkg::RED_LSB +: npcs_pkg::CHAN_W],
               req_tdata[npcs_pkg::GREEN_LSB +: npcs_pkg::CHAN_W],
               req_tdata[npcs_pkg::BLUE_LSB +: npcs_pkg::CHAN_W],
               req_tdata[npcs_pkg::ALPHA_LSB +: npcs_pkg::CHAN_W]));
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_index_q.size() == 0) begin
            note_mismatch($sformatf("unexpected response palette_index=%0d", rsp_tdata));
         end else begin
            want = expected_index_q.pop_front();
            if (rsp_tdata !== want)
               note_mismatch($sformatf("palette_index expected %0d got %0d", want, rsp_tdata));
         end
      end
   end

   initial begin : run_sequence
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_register(npcs_pkg::CSR_PALETTE_IS_RGB565, 1'b0);
      set_register(npcs_pkg::CSR_PIXEL_HAS_ALPHA, 1'b0);

      // Every slot gets written before the first search reads it.
      for (int i = 0; i < PALETTE_SIZE; i++)
         queue_write(8'(i), 24'($urandom));

      // XRGB8888, alpha ignored
      queue_write(8'd0, 24'h123456);        // slot zero is stored but never searched
      queue_write(8'd255, 24'hFFFFFF);
      queue_write(8'd1, 24'h000000);
      queue_write(8'd40, 24'h000000);       // tie with slot 1, lower index wins
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'h12, 8'h34, 8'h56, 8'h7F);
      queue_write(8'd128, 24'h80FF01);
      queue_pixel(8'h80, 8'hFF, 8'h01, 8'h7F);
      wait_drained();

      // alpha mode: threshold on both sides plus extremes
      set_register(npcs_pkg::CSR_PIXEL_HAS_ALPHA, 1'b1);
      queue_pixel(8'h80, 8'hFF, 8'h01, 8'h7F);
      queue_pixel(8'h80, 8'hFF, 8'h01, 8'h80);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_drained();

      // RGB565 with alpha: upper entry bits must be ignored
      set_register(npcs_pkg::CSR_PALETTE_IS_RGB565, 1'b1);
      queue_write(8'd2, 24'hABFFFF);        // same colour as slot 255 once decoded
      queue_pixel(8'd248, 8'd252, 8'd248, 8'h80);
      queue_write(8'd3, 24'hFF0000);        // decodes to black
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h7F);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF);
      queue_write(8'd100, 24'h00F800);
      queue_pixel(8'hFF, 8'h00, 8'h00, 8'hC0);
      wait_drained();

      // RGB565 without alpha
      set_register(npcs_pkg::CSR_PIXEL_HAS_ALPHA, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h07, 8'h03, 8'h07, 8'h00);
      queue_random_mix(200);
      wait_drained();

      set_register(npcs_pkg::CSR_PALETTE_IS_RGB565, 1'b0);
      queue_random_mix(200);
      wait_drained();

      set_register(npcs_pkg::CSR_PIXEL_HAS_ALPHA, 1'b1);
      queue_random_mix(200);
      wait_drained();

      set_register(npcs_pkg::CSR_PALETTE_IS_RGB565, 1'b1);
      queue_random_mix(200);
      wait_drained();

      // Back-pressure: pixels keep coming while rsp is held off for a long time.
      pressure_on = 1'b1;
      for (int i = 0; i < 16; i++)
         queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(128, 255)));
      wait_drained();

      // Closing stretch: both sides streaming flat out.
      set_register(npcs_pkg::CSR_PALETTE_IS_RGB565, 1'b0);
      set_register(npcs_pkg::CSR_PIXEL_HAS_ALPHA, 1'b0);
      quiet_tail = 1'b1;
      queue_random_mix(150);
      wait_drained();

      if (mismatch_count == 0)
         $display("PASS nearest_palette_colour_search");
      else
         $display("FAIL nearest_palette_colour_search");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAIL nearest_palette_colour_search");
      $finish;
   end

endmodule
